@@ hdl/fsa_pkg.sv @@
// fsa_pkg: shared constants and status codes for the fraction sum accumulator
// no dependencies
package fsa_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int ST_W  = 2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF      = 2'd2;
endpackage

@@ hdl/fsa_if.sv @@
// fsa_in_if, fsa_out_if: valid/ready channels for fractions and results
// depends on fsa_pkg
interface fsa_in_if;
  import fsa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] numerator;
  logic [DEN_W-1:0]        denominator;
  logic                    first;
  logic                    last;
  modport source (output valid, numerator, denominator, first, last, input ready);
  modport sink   (input valid, numerator, denominator, first, last, output ready);
endinterface

interface fsa_out_if;
  import fsa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] sum_numerator;
  logic [DEN_W-1:0]        sum_denominator;
  logic [ST_W-1:0]         status;
  modport source (output valid, sum_numerator, sum_denominator, status, input ready);
  modport sink   (input valid, sum_numerator, sum_denominator, status, output ready);
endinterface

@@ hdl/fsa_mul.sv @@
// fsa_mul: bit-serial shift-add multiplier, 32x32 unsigned to 64 bits
// depends on fsa_pkg
module fsa_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] p
);
  import fsa_pkg::*;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] a_r, a_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] hi;

  // one multiplier bit per cycle: add then shift right
  always_comb begin
    hi       = {1'b0, acc_r[63:32]} + {1'b0, (a_r[0] ? b : 32'd0)};
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0; a_nxt = a; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {hi, acc_r[31:1]};
      a_nxt   = a_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
  end

  assign done = busy_r && cnt_r == 6'd31;
  assign p    = {hi, acc_r[31:1]};
endmodule

@@ hdl/fsa_div.sv @@
// fsa_div: restoring divider, one quotient bit per cycle, 64-bit operands
// depends on fsa_pkg
module fsa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);
  import fsa_pkg::*;
  logic [63:0] q_r, q_nxt, r_r, r_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  always_comb begin
    trial    = {r_r, q_r[63]};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = num; r_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        r_nxt = 64'(trial - {1'b0, den});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done = busy_r && cnt_r == 7'd63;
  assign quo  = q_nxt;
  assign rem  = r_nxt;
endmodule

@@ hdl/fraction_sum_accumulator.sv @@
// fraction_sum_accumulator: top level, sequencer around serial mul and div
// depends on fsa_pkg, fsa_if, fsa_mul, fsa_div
//
// usage: fractions enter on the in channel (numerator, denominator, first,
// last); a transaction marked last produces one result transaction on the
// out channel with the reduced running sum and a sticky status
// (0 ok, 1 zero denominator, 2 overflow). a first transaction restarts the
// sum. one fraction is processed at a time: a first item or zero
// denominator goes straight to the result check; an addition runs three
// serial multiplies, a euclidean gcd of one serial divide per remainder
// step (up to about 90 steps, typically far fewer), then two serial
// divides. the result is valid from the cycle after it is loaded into
// its output register.
// reset (synchronous, rst_n low) loads 0/1 and clears status. the result
// is held in its own output register, so the next fraction is taken while
// the receiver stalls; only a second result waits until the first has left.
module fraction_sum_accumulator #(
  parameter int WORD_BITS = fsa_pkg::WORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  fsa_in_if.sink    in_ch,
  fsa_out_if.source out_ch
);
  import fsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_ADD, S_GCD, S_D1, S_D2, S_CHK, S_OUT
  } state_t;

  localparam logic [63:0] HI = 64'((64'd1 << (WORD_BITS - 1)) - 64'd1);

  state_t state_r;
  logic signed [NUM_W-1:0] acc_n_r, in_n_r, out_n_r;
  logic [DEN_W-1:0]        acc_d_r, in_d_r, out_d_r;
  logic [ST_W-1:0]         err_r, out_st_r;
  logic                    last_r, neg_r;
  logic [63:0]             t1_r, t2_r, sd_r, mag_r, ga_r, gb_r, rn_r, rd_r;
  logic                    out_valid_r;
  logic                    load_out;

  logic        m_start, m_done, d_start, d_done;
  logic [31:0] m_a, m_b;
  logic [63:0] m_p, d_num, d_den, d_quo, d_rem;
  logic        fits_in;

  fsa_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p));
  fsa_div u_div (.clk, .rst_n, .start(d_start), .num(d_num), .den(d_den),
                 .done(d_done), .quo(d_quo), .rem(d_rem));

  assign in_ch.ready = (state_r == S_IDLE);
  assign fits_in = (64'(signed'(in_ch.numerator)) <= signed'(HI))
                && (64'(signed'(in_ch.numerator)) >= -signed'(HI) - 64'sd1)
                && ({33'd0, in_ch.denominator} <= HI);

  // output register is free or being emptied this cycle
  assign load_out = (state_r == S_CHK) && last_r && (!out_valid_r || out_ch.ready);

  // start pulses for the serial units, one per state entry and one per further gcd step
  logic first_cyc_r;
  always_comb begin
    m_start = first_cyc_r && (state_r == S_M1 || state_r == S_M2 || state_r == S_M3);
    d_start = first_cyc_r && (state_r == S_GCD || state_r == S_D1 || state_r == S_D2);
    m_a = 32'(acc_n_r[31] ? 32'(-acc_n_r) : acc_n_r);
    m_b = {1'b0, in_d_r};
    case (state_r)
      S_M2: begin m_a = in_n_r[31] ? 32'(-in_n_r) : in_n_r; m_b = {1'b0, acc_d_r}; end
      S_M3: begin m_a = {1'b0, acc_d_r}; m_b = {1'b0, in_d_r}; end
      default: ;
    endcase
    d_num = ga_r;
    d_den = gb_r;
    case (state_r)
      S_D1: begin d_num = mag_r; d_den = ga_r; end
      S_D2: begin d_num = sd_r;  d_den = ga_r; end
      default: ;
    endcase
  end

  logic nfit;
  assign nfit = (rn_r > (neg_r ? HI + 64'd1 : HI)) || (rd_r > HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; first_cyc_r <= 1'b0; out_valid_r <= 1'b0;
      acc_n_r <= '0; acc_d_r <= DEN_W'(1); err_r <= ST_OK;
    end else begin
      first_cyc_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          in_n_r <= in_ch.numerator; in_d_r <= in_ch.denominator;
          last_r <= in_ch.last;
          state_r <= S_CHK;
          if (in_ch.first) begin
            err_r <= ST_OK; acc_n_r <= '0; acc_d_r <= DEN_W'(1);
            if (in_ch.denominator == '0) err_r <= ST_ZERO_DEN;
            else if (!fits_in) err_r <= ST_OVF;
            else begin acc_n_r <= in_ch.numerator; acc_d_r <= in_ch.denominator; end
          end else if (in_ch.denominator == '0) begin
            if (err_r == ST_OK) err_r <= ST_ZERO_DEN;
          end else begin
            state_r <= S_M1; first_cyc_r <= 1'b1;
          end
        end
        S_M1: if (m_done) begin
          t1_r <= m_p; state_r <= S_M2; first_cyc_r <= 1'b1;
        end
        S_M2: if (m_done) begin
          t2_r <= m_p; state_r <= S_M3; first_cyc_r <= 1'b1;
        end
        S_M3: if (m_done) begin
          sd_r <= m_p; state_r <= S_ADD;
        end
        S_ADD: begin
          // signed sum of the two cross terms, in sign-magnitude form
          if (acc_n_r[31] == in_n_r[31]) begin
            mag_r <= t1_r + t2_r; neg_r <= acc_n_r[31];
          end else if (t1_r >= t2_r) begin
            mag_r <= t1_r - t2_r; neg_r <= acc_n_r[31] && (t1_r != t2_r);
          end else begin
            mag_r <= t2_r - t1_r; neg_r <= in_n_r[31];
          end
          // seed the gcd with the magnitude and the denominator product
          ga_r <= (acc_n_r[31] == in_n_r[31]) ? t1_r + t2_r
                : (t1_r >= t2_r ? t1_r - t2_r : t2_r - t1_r);
          gb_r <= sd_r;
          state_r <= S_GCD;
          first_cyc_r <= 1'b1;
        end
        S_GCD: if (d_done) begin
          ga_r <= gb_r; gb_r <= d_rem;
          if (d_rem == '0) begin state_r <= S_D1; end
          first_cyc_r <= 1'b1;
        end
        S_D1: if (d_done) begin
          rn_r <= d_quo; state_r <= S_D2; first_cyc_r <= 1'b1;
        end
        S_D2: if (d_done) begin
          rd_r <= d_quo; state_r <= S_OUT;
        end
        S_OUT: begin
          if (nfit) begin
            if (err_r == ST_OK) err_r <= ST_OVF;
          end else begin
            acc_n_r <= neg_r ? 32'(-rn_r) : rn_r[31:0];
            acc_d_r <= rd_r[DEN_W-1:0];
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (!last_r) state_r <= S_IDLE;
          else if (load_out) begin
            out_n_r <= acc_n_r; out_d_r <= acc_d_r; out_st_r <= err_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // gcd(x,0) handled: sd is never zero so first divide is x mod sd
  assign out_ch.valid           = out_valid_r;
  assign out_ch.sum_numerator   = out_n_r;
  assign out_ch.sum_denominator = out_d_r;
  assign out_ch.status          = out_st_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_n_r))
    else $error("result changed while stalled");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_d_r != '0) else $error("zero denominator held");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    err_r == ST_OK || err_r == ST_ZERO_DEN || err_r == ST_OVF) else $error("bad status");
endmodule

@@ test/fsa_sum_checker.sv @@
`timescale 1ns / 1ps
// fsa_sum_checker: watches the fraction and result channels, predicts the running sum
// and compares every result transaction; depends on fsa_pkg and fsa_if
module fsa_sum_checker (
  input  logic clk,
  input  logic rst_n,
  fsa_in_if    in_ch,
  fsa_out_if   out_ch,
  output int   fail_count,
  output int   pending_sums,
  output int   sums_seen
);
  import fsa_pkg::*;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic [ST_W-1:0]         status;
  } sum_t;

  sum_t        sum_q[$];
  longint      run_num;
  bit [63:0]   run_den;
  bit [ST_W-1:0] run_status;

  function automatic bit [63:0] euclid(bit [63:0] a, bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit in_range(longint n, bit [63:0] d);
    longint hi;
    hi = (longint'(1) <<< (WORD_BITS_DEF - 1)) - 1;
    return (n >= -hi - 1) && (n <= hi) && (d <= 64'(hi));
  endfunction

  function automatic void flag(bit [ST_W-1:0] code);
    if (run_status == ST_OK) run_status = code;
  endfunction

  // takes one fraction into the running sum
  function automatic void take_fraction(logic signed [NUM_W-1:0] n_in,
                                        logic [DEN_W-1:0] d_in, logic is_first);
    longint    n, sn, rn;
    bit [63:0] d, sd, mag, g;
    bit        neg;
    n = longint'(n_in);
    d = 64'(d_in);
    if (is_first) begin
      run_status = ST_OK;
      run_num = 0;
      run_den = 1;
      if (d == 0) flag(ST_ZERO_DEN);
      else if (!in_range(n, d)) flag(ST_OVF);
      else begin
        run_num = n;
        run_den = d;
      end
    end else if (d == 0) begin
      flag(ST_ZERO_DEN);
    end else begin
      sn = run_num * longint'(d) + n * longint'(run_den);
      sd = run_den * d;
      neg = sn < 0;
      mag = neg ? 64'(-sn) : 64'(sn);
      g = euclid(mag, sd);
      if (g != 0) begin
        mag = mag / g;
        sd = sd / g;
      end
      rn = neg ? -longint'(mag) : longint'(mag);
      if (in_range(rn, sd)) begin
        run_num = rn;
        run_den = sd;
      end else begin
        flag(ST_OVF);
      end
    end
  endfunction

  always @(posedge clk) begin
    sum_t want;
    sum_t got;
    if (!rst_n) begin
      run_num = 0;
      run_den = 1;
      run_status = ST_OK;
      fail_count <= 0;
      sums_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sums_seen <= sums_seen + 1;
        got = '{out_ch.sum_numerator, out_ch.sum_denominator, out_ch.status};
        if (sum_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transaction with nothing expected: %0d/%0d st %0d",
                     $realtime, got.num, got.den, got.status);
          fail_count <= fail_count + 1;
        end else begin
          want = sum_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: sum mismatch exp %0d/%0d st %0d got %0d/%0d st %0d",
                       $realtime, want.num, want.den, want.status,
                       got.num, got.den, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_fraction(in_ch.numerator, in_ch.denominator, in_ch.first);
        if (in_ch.last)
          sum_q.push_back('{NUM_W'(run_num), DEN_W'(run_den), run_status});
      end
    end
    pending_sums <= sum_q.size();
  end
endmodule

@@ test/fraction_sum_accumulator_tb.sv @@
`timescale 1ns / 1ps
// fraction_sum_accumulator_tb: drives fraction runs into the accumulator, stalls the result
// side at random and reports the verdict; depends on fsa_pkg, fsa_if, fsa_sum_checker
module fraction_sum_accumulator_tb;
  import fsa_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_sums, sums_seen;
  int   tx_idle, rx_idle;
  int   items_sent;
  int   quiet_cycles;

  fsa_in_if  in_ch ();
  fsa_out_if out_ch ();

  fraction_sum_accumulator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fsa_sum_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_sums (pending_sums),
    .sums_seen    (sums_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("fraction_sum_accumulator_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_fraction(logic signed [NUM_W-1:0] n, logic [DEN_W-1:0] d,
                               logic is_first, logic is_last);
    int gap;
    if ($urandom_range(99) < tx_idle) begin
      gap = $urandom_range(4, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.numerator   <= n;
    in_ch.denominator <= d;
    in_ch.first       <= is_first;
    in_ch.last        <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic logic signed [NUM_W-1:0] pick_num();
    int r;
    r = $urandom_range(99);
    if (r < 70) return NUM_W'($signed($urandom_range(100)) - 50);
    return $urandom;
  endfunction

  function automatic logic [DEN_W-1:0] pick_den();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75) return DEN_W'($urandom_range(60, 1));
    return DEN_W'($urandom);
  endfunction

  task automatic random_runs(int count);
    int mid;
    int r;
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // stray item with random marks
        send_fraction(pick_num(), pick_den(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        mid = $urandom_range(3);
        send_fraction(pick_num(), pick_den(), 1'b1, mid == 0 && r < 30);
        if (!(mid == 0 && r < 30)) begin
          repeat (mid) send_fraction(pick_num(), pick_den(), 1'b0, 1'b0);
          send_fraction(pick_num(), pick_den(), 1'b0, 1'b1);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.numerator = '0;
    in_ch.denominator = '0;
    in_ch.first = 1'b0;
    in_ch.last = 1'b0;
    quiet_cycles = 0;
    items_sent = 0;
    tx_idle = 36;
    rx_idle = 75;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no first item since reset: adds onto 0/1
    send_fraction(3, 4, 1'b0, 1'b1);
    // extremes loaded as entered
    send_fraction(32'sh7fffffff, 31'h7fffffff, 1'b1, 1'b1);
    send_fraction(32'sh80000000, 1, 1'b1, 1'b1);
    // overflow on add, then sticky
    send_fraction(32'sh80000000, 1, 1'b1, 1'b0);
    send_fraction(-1, 1, 1'b0, 1'b1);
    send_fraction(5, 1, 1'b0, 1'b1);
    // denominator product too wide
    send_fraction(1, 31'h7fffffff, 1'b1, 1'b0);
    send_fraction(1, 31'h7ffffffe, 1'b0, 1'b1);
    // zero denominator on first and later, sticky over an overflow
    send_fraction(7, 0, 1'b1, 1'b1);
    send_fraction(1, 2, 1'b1, 1'b0);
    send_fraction(1, 0, 1'b0, 1'b0);
    send_fraction(32'sh7fffffff, 1, 1'b0, 1'b1);
    // zero sum reduces to 0/1
    send_fraction(1, 2, 1'b1, 1'b0);
    send_fraction(-1, 2, 1'b0, 1'b1);
    // negative and zero numerators with reduction
    send_fraction(-6, 8, 1'b1, 1'b0);
    send_fraction(0, 5, 1'b0, 1'b0);
    send_fraction(-2, 12, 1'b0, 1'b1);
    send_fraction(0, 3, 1'b1, 1'b1);

    random_runs(360);
    tx_idle = 75;
    rx_idle = 36;
    random_runs(360);
    tx_idle = 0;
    rx_idle = 0;
    random_runs(360);
    in_ch.valid <= 1'b0;

    while (pending_sums != 0) @(posedge clk);
    repeat (7000) @(posedge clk);
    $display("sent %0d fractions in runs of varying length, checked %0d sums", items_sent,
             sums_seen);
    $display("covered extremes, zero denominators, overflow, and three stall profiles");
    if (fail_count == 0) begin
      $display("fraction_sum_accumulator_tb OK");
    end else begin
      $display("fraction_sum_accumulator_tb NOT OK");
    end
    $finish;
  end
endmodule
